@@ rtl/core/nds_pkg.sv @@
// Shared types and constants for the neighbour divisor search core.
`timescale 1ns / 1ps
`default_nettype none

package nds_pkg;

  // Search direction codes.
  localparam logic MODE_NEXT = 1'b0;
  localparam logic MODE_PREV = 1'b1;

  // Status handed from the remainder unit to the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } nds_rem_status_t;

endpackage

`default_nettype wire

@@ rtl/core/nds_if.sv @@
// Valid/ready channel interfaces for the request and result words.
`timescale 1ns / 1ps
`default_nettype none

interface nds_in_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [DATA_WIDTH-1:0] number;
  logic signed [DATA_WIDTH-1:0] start_req;

  modport source (output valid, mode, number, start_req, input ready);
  modport sink   (input valid, mode, number, start_req, output ready);
endinterface

interface nds_out_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] divisor;

  modport source (output valid, divisor, input ready);
  modport sink   (input valid, divisor, output ready);
endinterface

`default_nettype wire

@@ rtl/core/neighbour_divisor_search_core.sv @@
// Top level: candidate sequencer around a shared serial remainder unit.
// One request word is taken at a time. The core walks candidate divisors
// upward (next mode) or downward (previous mode) and tests each with a
// bit-serial remainder unit. A request that falls back at once has its
// result word valid in the cycle right after the accepting edge; a search
// visits up to about number/2 candidates. The result word is held until
// taken, and in_ch.ready is high only while the core is idle.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_divisor_search_core
  import nds_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nds_in_if.sink    in_ch,
  nds_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TEST = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } nds_state_t;

  localparam logic signed [DATA_WIDTH-1:0] S_ZERO = '0;
  localparam logic signed [DATA_WIDTH-1:0] S_ONE  = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0]        U_ONE  = DATA_WIDTH'(1);

  nds_state_t            state_r, state_nxt;
  logic                  mode_r, mode_nxt;
  logic [DATA_WIDTH-1:0] n_r, n_nxt;
  logic [DATA_WIDTH-1:0] half_r, half_nxt;
  logic [DATA_WIDTH-1:0] d_r, d_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;

  logic signed [DATA_WIDTH-1:0] in_num, in_start;
  logic [DATA_WIDTH-1:0]        in_half, in_up, in_down, in_low;
  logic                         next_bad, prev_bad;
  nds_rem_status_t              rem_st;

  assign in_num   = in_ch.number;
  assign in_start = in_ch.start_req;
  assign in_half  = DATA_WIDTH'(in_num >>> 1);
  assign in_up    = DATA_WIDTH'(in_start + S_ONE);
  assign in_down  = DATA_WIDTH'(in_start - S_ONE);
  assign in_low   = (in_down > in_half) ? in_half : in_down;
  assign next_bad = (in_num <= S_ZERO) || (in_start <= S_ZERO) || (in_start >= in_num);
  assign prev_bad = (in_num <= S_ZERO) || (in_start <= S_ONE) || (in_start > in_num);

  // Candidate sequencer.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    n_nxt     = n_r;
    half_nxt  = half_r;
    d_nxt     = d_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.mode;
          n_nxt    = in_num;
          half_nxt = in_half;
          if (in_ch.mode == MODE_NEXT) begin
            d_nxt = in_up;
            if (next_bad) begin
              res_nxt   = U_ONE;
              state_nxt = ST_OUT;
            end else if (in_up > in_half) begin
              res_nxt   = in_num;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_TEST;
            end
          end else begin
            d_nxt = in_low;
            if (prev_bad) begin
              res_nxt   = in_num;
              state_nxt = ST_OUT;
            end else if (in_low <= U_ONE) begin
              res_nxt   = U_ONE;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_TEST;
            end
          end
        end
      end
      ST_TEST: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            res_nxt   = d_r;
            state_nxt = ST_OUT;
          end else if (mode_r == MODE_NEXT) begin
            d_nxt = d_r + U_ONE;
            if (d_r >= half_r) begin
              res_nxt   = n_r;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_TEST;
            end
          end else begin
            d_nxt = d_r - U_ONE;
            if (d_r <= DATA_WIDTH'(2)) begin
              res_nxt   = U_ONE;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_TEST;
            end
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    n_r    <= n_nxt;
    half_r <= half_nxt;
    d_r    <= d_nxt;
    res_r  <= res_nxt;
  end

  // Shared remainder unit tests one candidate per launch.
  nds_rem_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_TEST),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (rem_st)
  );

  // Handshake and result word.
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = (state_r == ST_OUT);
  assign out_ch.divisor = res_r;

endmodule

`default_nettype wire

@@ rtl/core/nds_rem_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module nds_rem_unit
  import nds_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output nds_rem_status_t            status
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH:0]   trial;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DATA_WIDTH-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = CW'(DATA_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DATA_WIDTH'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DATA_WIDTH-1:0];
      end
      quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath words are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  // The remainder is final in the cycle that done is high.
  assign status = '{done: done_r, zero: (rem_r == '0)};

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the neighbour divisor search core.
`timescale 1ns / 1ps
module testbench
  import nds_pkg::*;
();

  localparam int W = 16;
  // Worst case per word is about PROBE_CAP candidates plus the longest stall
  // and gap. That is taken over every word and then several times over.
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PROBE_CAP = 120;
  localparam int SETTLE_CYCLES = 200;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_TRICKLE
  } sink_style_t;

  logic clk;
  logic rst_n;

  nds_in_if  #(.DATA_WIDTH(W)) req_if ();
  nds_out_if #(.DATA_WIDTH(W)) res_if ();

  neighbour_divisor_search_core #(.DATA_WIDTH(W)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  logic signed [W-1:0] divisor_queue[$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  // Expected divisor for one request word. The number of candidates that
  // the search visits is handed back so that stimulus can bound run time.
  function automatic logic signed [W-1:0] predict_divisor(
    input logic m, input logic signed [W-1:0] number,
    input logic signed [W-1:0] start, output int probes);
    int n;
    int s;
    int d;
    logic signed [W-1:0] found;
    n = number;
    s = start;
    probes = 0;
    if (m == MODE_NEXT) begin
      found = 1;
      if (n > 0 && s > 0 && s < n) begin
        // No proper divisor lies above n/2, so the number itself is the answer.
        found = number;
        for (d = s + 1; d <= n / 2; d++) begin
          probes++;
          if (n % d == 0) begin
            found = d[W-1:0];
            break;
          end
        end
      end
    end else begin
      found = number;
      if (!(n <= 0 || s <= 1 || s > n)) begin
        d = s - 1;
        if (d < n && d > n / 2) begin
          d = n / 2;
        end
        found = 1;
        for (; d > 1; d--) begin
          probes++;
          if (n % d == 0) begin
            found = d[W-1:0];
            break;
          end
        end
      end
    end
    return found;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Compare each accepted result word with the oldest expected divisor.
  always @(posedge clk) begin : check_results
    logic signed [W-1:0] want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (divisor_queue.size() == 0) begin
        $error("divisor: expected none, actual %0d", res_if.divisor);
        error_count++;
      end else begin
        want = divisor_queue.pop_front();
        if (res_if.divisor !== want) begin
          $error("divisor: expected %0d, actual %0d", want, res_if.divisor);
          error_count++;
        end
      end
    end
  end

  // Result side back-pressure: open stretches, coin flips and long stalls.
  initial begin : sink_pattern
    sink_style_t style;
    int left;
    int hold;
    style = SINK_OPEN;
    left = 0;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        style = sink_style_t'($urandom_range(2));
        left = $urandom_range(300, 10);
      end
      left--;
      case (style)
        SINK_OPEN: begin
          res_if.ready <= 1'b1;
        end
        SINK_COIN: begin
          res_if.ready <= ($urandom_range(1) == 1);
        end
        default: begin
          if (hold == 0) begin
            res_if.ready <= 1'b1;
            hold = $urandom_range(40, 1);
          end else begin
            res_if.ready <= 1'b0;
            hold--;
          end
        end
      endcase
    end
  end

  // Send one request word in bursts with random gaps, and record its divisor.
  task automatic send_word(input logic m, input logic signed [W-1:0] n,
                           input logic signed [W-1:0] s);
    int gap;
    int probes;
    logic signed [W-1:0] want;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                            : $urandom_range(12, 1);
      gap = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.number    <= n;
    req_if.start_req <= s;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    want = predict_divisor(m, n, s, probes);
    divisor_queue.insert(divisor_queue.size(), want);
  endtask

  // Hold the request side off until every expected divisor has come back.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (divisor_queue.size() != 0) @(posedge clk);
  endtask

  // Requests that have no meaning, so each mode answers its fallback.
  task automatic test_directed_fallbacks();
    send_word(MODE_NEXT, 16'sd0, 16'sd5);
    send_word(MODE_NEXT, -16'sd32768, 16'sd3);
    send_word(MODE_NEXT, 16'sd10, 16'sd0);
    send_word(MODE_NEXT, 16'sd10, -16'sd32768);
    send_word(MODE_NEXT, 16'sd10, 16'sd10);
    send_word(MODE_NEXT, 16'sd32767, 16'sd32767);
    send_word(MODE_PREV, 16'sd0, 16'sd5);
    send_word(MODE_PREV, -16'sd32768, 16'sd100);
    send_word(MODE_PREV, 16'sd10, 16'sd1);
    send_word(MODE_PREV, 16'sd10, -16'sd5);
    send_word(MODE_PREV, 16'sd10, 16'sd11);
    send_word(MODE_PREV, -16'sd1, 16'sd32767);
  endtask

  // Real searches, including primes, no divisor in the lower half, and the
  // start above half the number in previous mode.
  task automatic test_directed_searches();
    send_word(MODE_NEXT, 16'sd12, 16'sd2);
    send_word(MODE_NEXT, 16'sd13, 16'sd1);
    send_word(MODE_NEXT, 16'sd12, 16'sd6);
    send_word(MODE_NEXT, 16'sd2, 16'sd1);
    send_word(MODE_NEXT, 16'sd32767, 16'sd1);
    send_word(MODE_NEXT, 16'sd32766, 16'sd16382);
    send_word(MODE_PREV, 16'sd12, 16'sd6);
    send_word(MODE_PREV, 16'sd7, 16'sd7);
    send_word(MODE_PREV, 16'sd2, 16'sd2);
    send_word(MODE_PREV, 16'sd32766, 16'sd32766);
    send_word(MODE_PREV, 16'sd32767, 16'sd2);
    send_word(MODE_PREV, 16'sd100, 16'sd100);
  endtask

  // Small numbers with starts around the valid window, mostly real searches.
  task automatic test_random_small(input int count);
    logic m;
    int n;
    int s;
    int probes;
    logic signed [W-1:0] unused;
    for (int i = 0; i < count; i++) begin
      do begin
        m = ($urandom_range(1) == 1) ? MODE_PREV : MODE_NEXT;
        n = ($urandom_range(7) == 0) ? int'($urandom_range(20)) - 20
                                     : int'($urandom_range(120, 1));
        s = int'($urandom_range(((n > 0) ? n : 0) + 6)) - 3;
        unused = predict_divisor(m, n[W-1:0], s[W-1:0], probes);
      end while (probes > PROBE_CAP);
      send_word(m, n[W-1:0], s[W-1:0]);
    end
  endtask

  // Large positive numbers with starts placed so the search stays short.
  task automatic test_random_large_windows(input int count);
    logic m;
    int n;
    int s;
    int probes;
    logic signed [W-1:0] unused;
    for (int i = 0; i < count; i++) begin
      do begin
        m = ($urandom_range(1) == 1) ? MODE_PREV : MODE_NEXT;
        n = $urandom_range(32767, 1000);
        if (m == MODE_NEXT) begin
          s = $urandom_range(n, n / 2 - 40);
        end else if ($urandom_range(1) == 1) begin
          s = $urandom_range(60, 2);
        end else begin
          s = $urandom_range(n + 1, n / 2 + 2);
        end
        unused = predict_divisor(m, n[W-1:0], s[W-1:0], probes);
      end while (probes > PROBE_CAP);
      send_word(m, n[W-1:0], s[W-1:0]);
    end
  endtask

  // Full range words on both fields; long searches are redrawn.
  task automatic test_random_wide(input int count);
    logic m;
    logic signed [W-1:0] n;
    logic signed [W-1:0] s;
    int probes;
    logic signed [W-1:0] unused;
    for (int i = 0; i < count; i++) begin
      do begin
        m = ($urandom_range(1) == 1) ? MODE_PREV : MODE_NEXT;
        n = W'($urandom_range(16'hFFFF));
        s = W'($urandom_range(16'hFFFF));
        unused = predict_divisor(m, n, s, probes);
      end while (probes > PROBE_CAP);
      send_word(m, n, s);
    end
  endtask

  // Test sequence.
  initial begin
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= MODE_NEXT;
    req_if.number    <= '0;
    req_if.start_req <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fallbacks();
    test_directed_searches();
    wait_for_results();
    test_random_small(1200);
    wait_for_results();
    test_random_large_windows(400);
    test_random_wide(300);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
